// ===== hw/rtl/wtos_pkg.sv =====
// Shared types, widths, reset values and helpers for the wheel trip
// odometer and speedometer. No dependencies.
`timescale 1ns / 1ps

package wtos_pkg;

    localparam int TRIP_WIDTH     = 40;
    localparam int INTERVAL_WIDTH = 16;

    localparam int OUT_TRIP_W = 40;
    localparam int SPEED_W    = 10;
    localparam int LEVEL_W    = 2;
    localparam int CIRC_W     = 12;
    localparam int STEP_W     = 20;
    localparam int DEAD_W     = 8;
    localparam int HOLD_W     = 16;
    localparam int LSTEP_W    = 14;
    localparam int QUIET_W    = 8;
    localparam int HELD_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // speed = (circ*36 + 5*E) / (10*E)
    localparam int NUM_W     = ((INTERVAL_WIDTH + 3 > 18) ? INTERVAL_WIDTH + 3 : 18) + 1;
    localparam int DEN_W     = INTERVAL_WIDTH + 4;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    localparam logic [CIRC_W-1:0]  CIRC_RST  = CIRC_W'(1676);
    localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(10000);
    localparam logic [DEAD_W-1:0]  WDEAD_RST = DEAD_W'(20);
    localparam logic [DEAD_W-1:0]  BDEAD_RST = DEAD_W'(30);
    localparam logic [HOLD_W-1:0]  HOLD_RST  = HOLD_W'(4000);
    localparam logic [LSTEP_W-1:0] LSTEP_RST = LSTEP_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CIRC  = 3'd0,
        CFG_STEP  = 3'd1,
        CFG_WDEAD = 3'd2,
        CFG_BDEAD = 3'd3,
        CFG_HOLD  = 3'd4,
        CFG_LSTEP = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_WHEEL,
        ST_DIV,
        ST_SPEED,
        ST_DOWN,
        ST_UP,
        ST_RST,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic wheel;
        logic speed;
        logic down;
        logic up;
        logic rst_chk;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic btn_ok;
        logic div_busy;
        logic out_full;
    } dp_stat_t;

    function automatic logic [TRIP_WIDTH-1:0] trip_add(input logic [TRIP_WIDTH-1:0] trip,
                                                       input logic [STEP_W-1:0] amount);
        logic [TRIP_WIDTH:0] sum;
        sum = {1'b0, trip} + (TRIP_WIDTH + 1)'(amount);
        return sum[TRIP_WIDTH] ? '1 : sum[TRIP_WIDTH-1:0];
    endfunction

    function automatic logic [TRIP_WIDTH-1:0] trip_sub(input logic [TRIP_WIDTH-1:0] trip,
                                                       input logic [STEP_W-1:0] amount);
        logic [TRIP_WIDTH-1:0] amt;
        amt = TRIP_WIDTH'(amount);
        return (amt >= trip) ? '0 : trip - amt;
    endfunction

endpackage

// ===== hw/rtl/wtos_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on wtos_pkg.
`timescale 1ns / 1ps

module wtos_div
    import wtos_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DEN_W:0]       shifted;
    logic [DEN_W:0]       trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        trial     = shifted - {1'b0, den};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            cnt_next  = DIV_CNT_W'(NUM_W);
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den})
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

// ===== hw/rtl/wtos_dp.sv =====
// Datapath: config registers, time counters, trip and speed state,
// speed divider and output register. Depends on wtos_pkg, wtos_div.
`timescale 1ns / 1ps

module wtos_dp
    import wtos_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  wheel_edge,
    input  logic                  trip_up_pressed,
    input  logic                  trip_down_pressed,
    input  logic                  reset_pressed,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [OUT_TRIP_W-1:0] trip_distance_mm,
    output logic [SPEED_W-1:0]    speed_kmh,
    output logic [LEVEL_W-1:0]    hold_level
);

    // configuration
    logic [CIRC_W-1:0]  circ_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [DEAD_W-1:0]  wdead_reg;
    logic [DEAD_W-1:0]  bdead_reg;
    logic [HOLD_W-1:0]  hold_reg;
    logic [LSTEP_W-1:0] lstep_reg;

    // latched item
    logic edge_in_reg, up_in_reg, down_in_reg, rst_in_reg;

    // state
    logic [INTERVAL_WIDTH-1:0] since_reg, since_next;
    logic [INTERVAL_WIDTH-1:0] e_reg;
    logic [QUIET_W-1:0]        quiet_reg, quiet_next;
    logic [HELD_W-1:0]         held_reg, held_next;
    logic [TRIP_WIDTH-1:0]     trip_reg, trip_next;
    logic [SPEED_W-1:0]        speed_reg, speed_next;
    logic [LEVEL_W-1:0]        level_reg, level_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_TRIP_W-1:0] out_trip_reg;
    logic [SPEED_W-1:0]    out_speed_reg;
    logic [LEVEL_W-1:0]    out_level_reg;

    logic [INTERVAL_WIDTH-1:0] elapsed;
    logic [QUIET_W-1:0]        quiet_inc;
    logic [HELD_W-1:0]         held_inc;
    logic [HELD_W-1:0]         held_eff;
    logic [HELD_W:0]           thr1, thr2, thr3;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic [NUM_W-1:0]          div_quo;
    logic                      div_busy;
    logic [63:0]               trip_ext;

    assign elapsed   = (since_reg == '1) ? since_reg : INTERVAL_WIDTH'(since_reg + 1'b1);
    assign quiet_inc = (quiet_reg == '1) ? quiet_reg : QUIET_W'(quiet_reg + 1'b1);
    assign held_inc  = (held_reg == '1) ? held_reg : HELD_W'(held_reg + 1'b1);
    assign held_eff  = rst_in_reg ? held_reg : '0;

    assign thr1 = (HELD_W + 1)'(lstep_reg);
    assign thr2 = thr1 << 1;
    assign thr3 = thr1 + thr2;

    // circ*36 + 5*E and 10*E
    assign div_num = (NUM_W'(circ_reg) << 5) + (NUM_W'(circ_reg) << 2)
                   + (NUM_W'(e_reg) << 2) + NUM_W'(e_reg);
    assign div_den = (DEN_W'(e_reg) << 3) + (DEN_W'(e_reg) << 1);

    wtos_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.wheel),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    always_comb
    begin
        since_next     = since_reg;
        quiet_next     = quiet_reg;
        held_next      = held_reg;
        trip_next      = trip_reg;
        speed_next     = speed_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.prep)
        begin
            since_next = edge_in_reg ? '0 : elapsed;
            quiet_next = quiet_inc;
            held_next  = held_inc;
        end
        if (cmd.wheel)
            trip_next = trip_add(trip_reg, STEP_W'(circ_reg));
        if (cmd.speed)
            speed_next = (div_quo > NUM_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[SPEED_W-1:0];
        if (cmd.down && down_in_reg)
        begin
            trip_next  = trip_sub(trip_reg, step_reg);
            quiet_next = '0;
        end
        if (cmd.up && up_in_reg)
        begin
            trip_next  = trip_add(trip_reg, step_reg);
            quiet_next = '0;
        end
        if (cmd.rst_chk)
        begin
            held_next = held_eff;
            if (!rst_in_reg)
                level_next = '0;
            if (trip_reg != '0 && held_eff >= hold_reg)
            begin
                trip_next  = '0;
                level_next = '0;
            end
            if ({1'b0, held_eff} > thr1)
                level_next = LEVEL_W'(1);
            if ({1'b0, held_eff} > thr2)
                level_next = LEVEL_W'(2);
            if ({1'b0, held_eff} > thr3)
                level_next = LEVEL_W'(3);
        end
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg      <= CIRC_RST;
            step_reg      <= STEP_RST;
            wdead_reg     <= WDEAD_RST;
            bdead_reg     <= BDEAD_RST;
            hold_reg      <= HOLD_RST;
            lstep_reg     <= LSTEP_RST;
            since_reg     <= '0;
            quiet_reg     <= '0;
            held_reg      <= '0;
            trip_reg      <= '0;
            speed_reg     <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_CIRC:  circ_reg  <= cfg_data[CIRC_W-1:0];
                    CFG_STEP:  step_reg  <= cfg_data[STEP_W-1:0];
                    CFG_WDEAD: wdead_reg <= cfg_data[DEAD_W-1:0];
                    CFG_BDEAD: bdead_reg <= cfg_data[DEAD_W-1:0];
                    CFG_HOLD:  hold_reg  <= cfg_data[HOLD_W-1:0];
                    CFG_LSTEP: lstep_reg <= cfg_data[LSTEP_W-1:0];
                    default:   ;
                endcase
            end
            since_reg     <= since_next;
            quiet_reg     <= quiet_next;
            held_reg      <= held_next;
            trip_reg      <= trip_next;
            speed_reg     <= speed_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign trip_ext = 64'(trip_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            edge_in_reg <= wheel_edge;
            up_in_reg   <= trip_up_pressed;
            down_in_reg <= trip_down_pressed;
            rst_in_reg  <= reset_pressed;
        end
        if (cmd.prep)
            e_reg <= elapsed;
        if (cmd.out_load)
        begin
            out_trip_reg  <= trip_ext[OUT_TRIP_W-1:0];
            out_speed_reg <= speed_reg;
            out_level_reg <= level_reg;
        end
    end

    // edge_ok is read in the prep cycle, before since_reg moves
    assign stat.edge_ok  = edge_in_reg && (elapsed > INTERVAL_WIDTH'(wdead_reg));
    assign stat.btn_ok   = quiet_reg >= bdead_reg;
    assign stat.div_busy = div_busy;
    assign stat.out_full = out_valid_reg && out_stall;

    assign out_valid        = out_valid_reg;
    assign trip_distance_mm = out_trip_reg;
    assign speed_kmh        = out_speed_reg;
    assign hold_level       = out_level_reg;

endmodule

// ===== hw/rtl/wtos_ctrl.sv =====
// Sequencer for one tick item: counters, wheel, divide, buttons, output.
// Depends on wtos_pkg.
`timescale 1ns / 1ps

module wtos_ctrl
    import wtos_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = stat.edge_ok ? ST_WHEEL : ST_DOWN;
            end
            ST_WHEEL:
            begin
                cmd.wheel  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!stat.div_busy)
                    state_next = ST_SPEED;
            end
            ST_SPEED:
            begin
                cmd.speed  = 1'b1;
                state_next = ST_DOWN;
            end
            ST_DOWN:
            begin
                // inside the button dead time nothing else is handled
                if (stat.btn_ok)
                begin
                    cmd.down   = 1'b1;
                    state_next = ST_UP;
                end
                else
                    state_next = ST_OUT;
            end
            ST_UP:
            begin
                cmd.up     = 1'b1;
                state_next = ST_RST;
            end
            ST_RST:
            begin
                cmd.rst_chk = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/wheel_trip_odometer_speedometer_top.sv =====
// Wheel trip odometer and speedometer, one item per millisecond tick.
// Each item runs IDLE, PREP, WHEEL/DIV/SPEED for a counted wheel edge,
// DOWN, then UP and RST unless inside the button dead time, then OUT; the
// bit-serial speed divider is the longest step. One item at a time.
// Reset (rst_n, async, active low): registers to their defaults, all
// counters, trip, speed and level to zero, output empty.
`timescale 1ns / 1ps

module wheel_trip_odometer_speedometer_top
    import wtos_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tick items
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  wheel_edge,
    input  logic                  trip_up_pressed,
    input  logic                  trip_down_pressed,
    input  logic                  reset_pressed,
    // results
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_TRIP_W-1:0] trip_distance_mm,
    output logic [SPEED_W-1:0]    speed_kmh,
    output logic [LEVEL_W-1:0]    hold_level,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // register writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    // controller: IDLE takes the item, then counters, wheel edge and
    // division, down/up buttons, reset hold, and the output load
    wtos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: holds all state; the output register lets the next
    // item start while a result is still stalled
    wtos_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .wheel_edge        (wheel_edge),
        .trip_up_pressed   (trip_up_pressed),
        .trip_down_pressed (trip_down_pressed),
        .reset_pressed     (reset_pressed),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .trip_distance_mm  (trip_distance_mm),
        .speed_kmh         (speed_kmh),
        .hold_level        (hold_level)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for wheel_trip_odometer_speedometer_top: ticks are checked against a
// built-in odometer predictor. Depends on wtos_pkg and the top-level RTL only.

module tb_top;
    import wtos_pkg::*;

    // Longest quiet stretch of a correct run: an item with a counted edge, a receiver stall
    // run, the longest sender gap, the settle. Taken well over that.
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 40;    // above the worst item latency
    localparam int          LONG_TICKS     = 140;   // reset hold that reaches the clear
    localparam logic [63:0] TRIP_TOP       = (64'd1 << TRIP_WIDTH) - 1;
    localparam logic [63:0] INTERVAL_TOP   = (64'd1 << INTERVAL_WIDTH) - 1;
    localparam logic [63:0] QUIET_TOP      = (64'd1 << QUIET_W) - 1;
    localparam logic [63:0] HELD_TOP       = (64'd1 << HELD_W) - 1;
    localparam logic [63:0] SPEED_TOP      = (64'd1 << SPEED_W) - 1;

    // one reading of the display outputs
    typedef struct packed {
        logic [OUT_TRIP_W-1:0] trip_mm;
        logic [SPEED_W-1:0]    speed;
        logic [LEVEL_W-1:0]    level;
    } reading_t;

    // shadow of the register file
    typedef struct packed {
        logic [CIRC_W-1:0]  circ_mm;
        logic [STEP_W-1:0]  step_mm;
        logic [DEAD_W-1:0]  wheel_dead;
        logic [DEAD_W-1:0]  button_dead;
        logic [HOLD_W-1:0]  clear_hold;
        logic [LSTEP_W-1:0] level_step;
    } odo_regs_t;

    // predicted internal state of the odometer
    typedef struct packed {
        logic [TRIP_WIDTH-1:0]     trip;
        logic [INTERVAL_WIDTH-1:0] since_edge;
        logic [QUIET_W-1:0]        quiet;
        logic [HELD_W-1:0]         held;
        logic [SPEED_W-1:0]        speed;
        logic [LEVEL_W-1:0]        level;
    } odo_state_t;

    logic                  clk               = 1'b0;
    logic                  rst_n             = 1'b0;
    logic                  in_valid          = 1'b0;
    logic                  in_stall;
    logic                  wheel_edge        = 1'b0;
    logic                  trip_up_pressed   = 1'b0;
    logic                  trip_down_pressed = 1'b0;
    logic                  reset_pressed     = 1'b0;
    logic                  out_valid;
    logic                  out_stall         = 1'b0;
    logic [OUT_TRIP_W-1:0] trip_distance_mm;
    logic [SPEED_W-1:0]    speed_kmh;
    logic [LEVEL_W-1:0]    hold_level;
    logic                  cfg_valid         = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index         = '0;
    logic [CFG_DATA_W-1:0] cfg_data          = '0;

    odo_regs_t   regs_sh;
    odo_state_t  odo;
    reading_t    pending_readings[$];
    int unsigned ticks_sent       = 0;
    int unsigned random_ticks     = 0;
    int unsigned readings_checked = 0;
    int unsigned reg_writes       = 0;
    int unsigned mismatches       = 0;
    int unsigned idle_cycles      = 0;
    int unsigned burst_left       = 0;
    logic        no_idle          = 1'b0;   // stretches with no sender gaps and no stalls

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    wheel_trip_odometer_speedometer_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .wheel_edge        (wheel_edge),
        .trip_up_pressed   (trip_up_pressed),
        .trip_down_pressed (trip_down_pressed),
        .reset_pressed     (reset_pressed),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .trip_distance_mm  (trip_distance_mm),
        .speed_kmh         (speed_kmh),
        .hold_level        (hold_level),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // trip increase, saturating at the top of the accumulator
    function automatic logic [TRIP_WIDTH-1:0] trip_plus(input logic [TRIP_WIDTH-1:0] trip,
                                                        input logic [63:0] amount);
        logic [63:0] sum;
        sum = 64'(trip) + amount;
        return (sum > TRIP_TOP) ? TRIP_TOP[TRIP_WIDTH-1:0] : sum[TRIP_WIDTH-1:0];
    endfunction

    // advance the odometer by one millisecond tick and return the displayed reading
    function automatic reading_t next_odometer_reading(input logic wheel_in,
                                                       input logic up_in,
                                                       input logic down_in,
                                                       input logic rst_in);
        logic [63:0] elapsed;
        logic [63:0] kmh;
        logic [63:0] quiet;
        logic [63:0] held;
        logic [63:0] lstep;
        reading_t    r;

        // wheel: interval count saturates, a too-close edge still restarts it
        elapsed = 64'(odo.since_edge);
        if (elapsed < INTERVAL_TOP)
            elapsed = elapsed + 1;
        if (wheel_in)
        begin
            if (elapsed > 64'(regs_sh.wheel_dead))
            begin
                // round(circ * 3.6 / interval)
                kmh       = (64'(regs_sh.circ_mm) * 36 + 5 * elapsed) / (10 * elapsed);
                odo.trip  = trip_plus(odo.trip, 64'(regs_sh.circ_mm));
                odo.speed = (kmh > SPEED_TOP) ? SPEED_TOP[SPEED_W-1:0] : kmh[SPEED_W-1:0];
            end
            odo.since_edge = '0;
        end
        else
            odo.since_edge = elapsed[INTERVAL_WIDTH-1:0];

        // buttons: both counters advance even inside the lockout
        quiet = 64'(odo.quiet);
        if (quiet < QUIET_TOP)
            quiet = quiet + 1;
        held = 64'(odo.held);
        if (held < HELD_TOP)
            held = held + 1;
        if (quiet >= 64'(regs_sh.button_dead))
        begin
            if (down_in)
            begin
                odo.trip = (64'(regs_sh.step_mm) >= 64'(odo.trip)) ? '0
                                                                   : odo.trip - regs_sh.step_mm;
                quiet    = 0;
            end
            if (up_in)
            begin
                odo.trip = trip_plus(odo.trip, 64'(regs_sh.step_mm));
                quiet    = 0;
            end
            if (!rst_in)
            begin
                held      = 0;
                odo.level = '0;
            end
            if (odo.trip != '0 && held >= 64'(regs_sh.clear_hold))
            begin
                odo.trip  = '0;
                odo.level = '0;
            end
            lstep = 64'(regs_sh.level_step);
            if (held > lstep)
                odo.level = 2'd1;
            if (held > 2 * lstep)
                odo.level = 2'd2;
            if (held > 3 * lstep)
                odo.level = 2'd3;
        end
        odo.quiet = quiet[QUIET_W-1:0];
        odo.held  = held[HELD_W-1:0];

        r.trip_mm = odo.trip[OUT_TRIP_W-1:0];
        r.speed   = odo.speed;
        r.level   = odo.level;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    // All three channels are sampled at the rising edge, before the nonblocking updates
    // of that edge land, so the bench sees exactly what the block sees.
    always @(posedge clk)
    begin : scoreboard
        reading_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_readings.size() == 0)
                    report_mismatch("result with nothing expected, trip",
                                    64'(trip_distance_mm), 64'd0);
                else
                begin
                    want = pending_readings.pop_front();
                    if (trip_distance_mm !== want.trip_mm)
                        report_mismatch("trip_distance_mm", 64'(trip_distance_mm),
                                        64'(want.trip_mm));
                    if (speed_kmh !== want.speed)
                        report_mismatch("speed_kmh", 64'(speed_kmh), 64'(want.speed));
                    if (hold_level !== want.level)
                        report_mismatch("hold_level", 64'(hold_level), 64'(want.level));
                    readings_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CIRC:  regs_sh.circ_mm     = cfg_data[CIRC_W-1:0];
                    CFG_STEP:  regs_sh.step_mm     = cfg_data[STEP_W-1:0];
                    CFG_WDEAD: regs_sh.wheel_dead  = cfg_data[DEAD_W-1:0];
                    CFG_BDEAD: regs_sh.button_dead = cfg_data[DEAD_W-1:0];
                    CFG_HOLD:  regs_sh.clear_hold  = cfg_data[HOLD_W-1:0];
                    CFG_LSTEP: regs_sh.level_step  = cfg_data[LSTEP_W-1:0];
                    default:   ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                pending_readings.push_back(next_odometer_reading(wheel_edge, trip_up_pressed,
                                                                 trip_down_pressed,
                                                                 reset_pressed));
                ticks_sent++;
            end
        end
    end

    // Receiver: switches between no stall, light random, periodic and heavy random stall.
    logic [1:0]  stall_style = 2'd0;
    logic [3:0]  stall_phase = 4'd0;
    int unsigned stall_left  = 0;

    always @(posedge clk)
    begin : stall_gen
        logic hold_off;
        case (stall_style)
            2'd0:    hold_off = 1'b0;
            2'd1:    hold_off = ($urandom_range(0, 99) < 30);
            2'd2:    hold_off = (stall_phase < 4'd5);
            default: hold_off = ($urandom_range(0, 99) < 75);
        endcase
        out_stall   <= hold_off && !no_idle;
        stall_phase <= stall_phase + 4'd1;
        if (stall_left == 0)
        begin
            stall_style <= 2'($urandom_range(0, 3));
            stall_left  <= $urandom_range(30, 300);
        end
        else
            stall_left <= stall_left - 1;
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles at %0t", idle_cycles, $time);
            $display("FAIL wheel_trip_odometer_speedometer_top");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sends one tick item; the sender runs in bursts with random gaps in between.
    // Returns at the edge that accepts the item, valid left high for a following item.
    task automatic send_tick(input logic wheel_in, input logic up_in,
                             input logic down_in, input logic rst_in);
        if (burst_left == 0)
        begin
            if (!no_idle && $urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left = burst_left - 1;
        in_valid          <= 1'b1;
        wheel_edge        <= wheel_in;
        trip_up_pressed   <= up_in;
        trip_down_pressed <= down_in;
        reset_pressed     <= rst_in;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Holds off the sender until every predicted reading has been checked.
    // At least one edge passes first, so the last accepted tick is already queued.
    task automatic wait_all_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_readings.size() != 0);
    endtask

    // cfg_valid stays high across back-to-back writes; set_config drops it.
    task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_writes++;
    endtask

    // Full register setup, done only with the block idle.
    task automatic set_config(input int unsigned circ_mm, input int unsigned step_mm,
                              input int unsigned wheel_dead, input int unsigned button_dead,
                              input int unsigned clear_ms, input int unsigned level_ms);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_CIRC, circ_mm);
        write_reg(CFG_STEP, step_mm);
        write_reg(CFG_WDEAD, wheel_dead);
        write_reg(CFG_BDEAD, button_dead);
        write_reg(CFG_HOLD, clear_ms);
        write_reg(CFG_LSTEP, level_ms);
        cfg_valid <= 1'b0;
    endtask

    // Random ticks with the current setup; reset is held in runs so levels and clears
    // are reached, the trip buttons are tapped at random.
    task automatic random_phase(input int unsigned n_ticks, input int unsigned edge_pct);
        int unsigned rst_left;
        logic        rst_level;
        rst_left  = 0;
        rst_level = 1'b0;
        for (int i = 0; i < n_ticks; i++)
        begin
            if (rst_left == 0)
            begin
                rst_level = ($urandom_range(0, 99) < 40);
                rst_left  = $urandom_range(1, 120);
            end
            rst_left = rst_left - 1;
            send_tick($urandom_range(0, 99) < edge_pct, $urandom_range(0, 99) < 15,
                      $urandom_range(0, 99) < 15, rst_level);
            random_ticks++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register reset values: 20 ms wheel lockout, 30 ms button lockout.
    task automatic test_power_on_defaults();
        random_phase(170, 6);
    endtask

    // Largest circumference, no wheel lockout: one- and two-tick intervals saturate speed.
    task automatic test_wheel_speed();
        set_config(4095, 1, 0, 0, 3, 1);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    endtask

    // Step of 1000000 mm: up, down, floor at zero, both buttons (down first), then a reset hold
    // that walks the level up and clears the trip, and the release.
    task automatic test_trip_buttons();
        set_config(4095, 1000000, 0, 0, 3, 1);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0);   // below zero: floors
        send_tick(1'b0, 1'b1, 1'b1, 1'b0);   // from zero: down then up
        send_tick(1'b0, 1'b1, 1'b1, 1'b0);
        repeat (4) send_tick(1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    // Smallest circumference and step: a rejected edge restarts the interval; a press
    // starts the button lockout, inside which a released reset leaves the level alone.
    task automatic test_dead_times();
        set_config(1, 0, 2, 3, 65535, 1);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);   // too close: rejected
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);   // three ticks after the rejected one
        repeat (3) send_tick(1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0, 1'b1);   // zero step press, lockout starts
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);   // lockout over: level drops
    endtask

    // Long lockouts: held up presses land once per button lockout while reset is held,
    // the hold walks the level up and clears the trip; after a long quiet wheel, a
    // counted and a rejected edge.
    task automatic test_long_hold();
        set_config(1, 1000000, 200, 40, 150, 40);
        no_idle = 1'b1;
        repeat (60) send_tick(1'b0, 1'b1, 1'b0, 1'b1);
        repeat (LONG_TICKS) send_tick(1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        no_idle = 1'b0;
    endtask

    // Three random setups: moderate, bottom extremes with a mid-phase drain, top
    // extremes opening with a stretch of no idling.
    task automatic test_random_ticks();
        set_config($urandom_range(1, 4095), $urandom_range(0, 50000), $urandom_range(0, 30),
                   $urandom_range(0, 15), $urandom_range(1, 60), $urandom_range(1, 20));
        random_phase(150, 20);

        set_config(1, $urandom_range(1, 3000), 0, 0, 1, 1);
        random_phase(70, 40);
        wait_all_results();
        random_phase(80, 40);

        set_config(4095, 1000000, $urandom_range(0, 10), $urandom_range(0, 40),
                   $urandom_range(30, 200), $urandom_range(5, 60));
        no_idle = 1'b1;
        random_phase(40, 30);
        no_idle = 1'b0;
        random_phase(110, 30);
    endtask

    initial
    begin
        regs_sh = '{circ_mm: CIRC_RST, step_mm: STEP_RST, wheel_dead: WDEAD_RST,
                    button_dead: BDEAD_RST, clear_hold: HOLD_RST, level_step: LSTEP_RST};
        odo     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_power_on_defaults();
        test_wheel_speed();
        test_trip_buttons();
        test_dead_times();
        test_long_hold();
        test_random_ticks();

        // drain, then leave room for any stray reading
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d ticks (%0d random) under %0d register writes.",
                 ticks_sent, random_ticks, reg_writes);
        $display("Checked %0d readings, %0d mismatches.", readings_checked, mismatches);
        if (mismatches == 0)
            $display("PASS wheel_trip_odometer_speedometer_top");
        else
            $display("FAIL wheel_trip_odometer_speedometer_top");
        $finish;
    end

endmodule
